// ----- rtl/ukfq_pkg.sv -----
// Shared types and constants for the unique-key FIFO queue.
// No dependencies; ukfq_ctrl and the top level refer to it by scoped names.
package ukfq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int KEY_W     = 32;
  localparam int VAL_W     = 32;
  localparam int ENTRY_W   = KEY_W + VAL_W;
  localparam int OCC_W     = 5;

  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DUP   = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic                    req_type;
    logic signed [KEY_W-1:0] item_key;
    logic signed [VAL_W-1:0] item_value;
  } in_req_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [KEY_W-1:0] out_key;
    logic signed [VAL_W-1:0] out_value;
    logic [OCC_W-1:0]        occupancy;
    logic                    is_empty;
  } out_res_t;

endpackage

// ----- rtl/ukfq_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ukfq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/ukfq_ctrl.sv -----
// Request sequencer: ring pointers, duplicate-key scan over the entry RAM,
// enqueue write and dequeue read. Depends on ukfq_pkg.
module ukfq_ctrl #(
  parameter int DEPTH = ukfq_pkg::DEPTH_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  ukfq_pkg::in_req_t              in_data,
  output logic                           ram_we,
  output logic [AW-1:0]                  ram_waddr,
  output logic [ukfq_pkg::ENTRY_W-1:0]   ram_wdata,
  output logic                           ram_re,
  output logic [AW-1:0]                  ram_raddr,
  input  logic [ukfq_pkg::ENTRY_W-1:0]   ram_rdata,
  output logic                           res_valid,
  input  logic                           res_ready,
  output ukfq_pkg::out_res_t             res
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_DEQ_RD = 4'b0100,
    S_REPLY  = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [AW-1:0]       head_r, head_nxt;
  logic [AW-1:0]       tail_r, tail_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [AW-1:0]       scan_ptr_r, scan_ptr_nxt;
  logic [CW-1:0]       scan_left_r, scan_left_nxt;
  logic                pend_r, pend_nxt;
  ukfq_pkg::in_req_t   req_r, req_nxt;
  ukfq_pkg::out_res_t  res_r, res_nxt;
  logic                hit;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign hit = pend_r &&
               (ram_rdata[ukfq_pkg::ENTRY_W-1:ukfq_pkg::VAL_W] == req_r.item_key);

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cnt_nxt       = cnt_r;
    scan_ptr_nxt  = scan_ptr_r;
    scan_left_nxt = scan_left_r;
    pend_nxt      = pend_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    ram_we        = 1'b0;
    ram_waddr     = tail_r;
    ram_wdata     = {req_r.item_key, req_r.item_value};
    ram_re        = 1'b0;
    ram_raddr     = scan_ptr_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt = in_data;
          if (in_data.req_type == ukfq_pkg::REQ_DEQ) begin
            if (cnt_r == '0) begin
              res_nxt.status    = ukfq_pkg::ST_EMPTY;
              res_nxt.out_key   = '0;
              res_nxt.out_value = '0;
              res_nxt.occupancy = ukfq_pkg::OCC_W'(cnt_r);
              res_nxt.is_empty  = 1'b1;
              state_nxt         = S_REPLY;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = head_r;
              state_nxt = S_DEQ_RD;
            end
          end else begin
            scan_ptr_nxt  = head_r;
            scan_left_nxt = cnt_r;
            pend_nxt      = 1'b0;
            state_nxt     = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        pend_nxt          = 1'b0;
        res_nxt.out_key   = '0;
        res_nxt.out_value = '0;
        res_nxt.occupancy = ukfq_pkg::OCC_W'(cnt_r);
        res_nxt.is_empty  = (cnt_r == '0);
        if (hit) begin
          res_nxt.status = ukfq_pkg::ST_DUP;
          state_nxt      = S_REPLY;
        end else if (scan_left_r != '0) begin
          ram_re        = 1'b1;
          ram_raddr     = scan_ptr_r;
          scan_ptr_nxt  = ptr_inc(scan_ptr_r);
          scan_left_nxt = scan_left_r - CW'(1);
          pend_nxt      = 1'b1;
        end else if (cnt_r == CW'(DEPTH)) begin
          res_nxt.status = ukfq_pkg::ST_FULL;
          state_nxt      = S_REPLY;
        end else begin
          ram_we            = 1'b1;
          tail_nxt          = ptr_inc(tail_r);
          cnt_nxt           = cnt_r + CW'(1);
          res_nxt.status    = ukfq_pkg::ST_OK;
          res_nxt.occupancy = ukfq_pkg::OCC_W'(cnt_nxt);
          res_nxt.is_empty  = 1'b0;
          state_nxt         = S_REPLY;
        end
      end
      S_DEQ_RD: begin
        head_nxt          = ptr_inc(head_r);
        cnt_nxt           = cnt_r - CW'(1);
        res_nxt.status    = ukfq_pkg::ST_OK;
        res_nxt.out_key   = ram_rdata[ukfq_pkg::ENTRY_W-1:ukfq_pkg::VAL_W];
        res_nxt.out_value = ram_rdata[ukfq_pkg::VAL_W-1:0];
        res_nxt.occupancy = ukfq_pkg::OCC_W'(cnt_nxt);
        res_nxt.is_empty  = (cnt_nxt == '0);
        state_nxt         = S_REPLY;
      end
      S_REPLY: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      scan_ptr_r  <= '0;
      scan_left_r <= '0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      scan_ptr_r  <= scan_ptr_nxt;
      scan_left_r <= scan_left_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    res_r <= res_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_REPLY);
  assign res       = res_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_write_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_SEARCH) && !hit && (scan_left_r == '0) &&
               (cnt_r != CW'(DEPTH)))
    else $error("RAM write outside a successful enqueue");

  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r == tail_r) |-> (cnt_r == '0) || (cnt_r == CW'(DEPTH)))
    else $error("ring pointers disagree with entry count");

  a_deq_read: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_data.req_type == ukfq_pkg::REQ_DEQ) && (cnt_r != '0))
    |=> (state_r == S_DEQ_RD) && (cnt_r != '0))
    else $error("dequeue of held entry did not read the head");

endmodule

// ----- rtl/unique_key_fifo_queue_unit.sv -----
// Top level of the unique-key FIFO queue: sequencer, entry RAM, result register.
// Depends on ukfq_pkg, ukfq_ram and ukfq_ctrl.
//
//   channel   direction  handshake            payload
//   in_*      input      in_valid/in_ready    ukfq_pkg::in_req_t   (req_type, key, value)
//   out_*     output     out_valid/out_ready  ukfq_pkg::out_res_t  (status, key, value,
//                                                                    occupancy, is_empty)
//
// Requests: an enqueue request scans every occupied entry from the head before it
//   writes at the tail, and a duplicate key ends the scan early;
//   the scan reads one RAM entry a cycle through the single read port.
//   A dequeue reads the head entry, and skips the read when the queue is empty.
// Reset: rst_n synchronous, active low; clears pointers, count and valid flags.
//   The entry RAM is not cleared; only occupied slots are ever read.
// Stalls: one request is in work at a time; a finished result moves to the
//   output register and waits there for out_ready while the next request runs.
module unique_key_fifo_queue_unit #(
  parameter int DEPTH = ukfq_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ukfq_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ukfq_pkg::out_res_t out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [ukfq_pkg::ENTRY_W-1:0] ram_wdata;
  logic                         ram_re;
  logic [AW-1:0]                ram_raddr;
  logic [ukfq_pkg::ENTRY_W-1:0] ram_rdata;

  logic                         res_valid;
  logic                         res_ready;
  ukfq_pkg::out_res_t           res;

  logic                         out_valid_r, out_valid_nxt;
  ukfq_pkg::out_res_t           out_data_r;
  logic                         load;

  // Sequence each request: scan for a duplicate key, write or read the ring.
  ukfq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Hold key and value side by side: key in the upper half of each word.
  ukfq_ram #(
    .WIDTH(ukfq_pkg::ENTRY_W),
    .DEPTH(DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Output register: take a finished result when empty or draining this cycle,
  // so the sequencer is free for the next request while this one waits.
  assign res_ready = !out_valid_r || out_ready;
  assign load      = res_valid && res_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload holds while out_valid is high and not yet taken.
  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
